// ===== hw/rtl/quadratic_probe_hash_table_top_assert.svh =====
// Assertion macros shared by the quadratic probe hash table RTL.
`ifndef QUADRATIC_PROBE_HASH_TABLE_TOP_ASSERT_SVH
`define QUADRATIC_PROBE_HASH_TABLE_TOP_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define QPHT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as the antecedent.
`define QPHT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define QPHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/qpht_pkg.sv =====
// Shared types, constants and control structures of the quadratic probe hash table.
`default_nettype none

package qpht_pkg;

  localparam int KEY_W           = 31;
  localparam int AGE_W           = 7;
  localparam int SIZE_W          = 7;
  localparam int SLOT_W          = 6;
  localparam int BIT_W           = $clog2(KEY_W);
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int APB_DATA_W      = 32;
  localparam int APB_ADDR_W      = 3;

  localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 7'd53;

  // Register index of table_size in the configuration map.
  localparam logic REG_TABLE_SIZE = 1'b0;

  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_USED    = 2'd1,
    MARK_DELETED = 2'd2
  } mark_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_DUP      = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_DELETE = 2'd2
  } command_t;

  // One table row as held in the slot memory.
  typedef struct packed {
    mark_t              mark;
    logic               gender;
    logic [AGE_W-1:0]   age;
    logic [KEY_W-1:0]   key;
  } entry_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic    load;
    logic    mod_en;
    logic    scan_init;
    logic    probe_init;
    logic    run;
    logic    probe;
    logic    clr_en;
    logic    wr_del;
    logic    wr_ins;
    logic    res_load;
    status_t res_status;
    logic    res_slot;
    logic    res_found;
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic mod_last;
    logic hit;
    logic miss;
    logic clr_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/qpht_dp.sv =====
// Datapath of the quadratic probe hash table: slot memory, remainder unit, probe and scan.
`default_nettype none

module qpht_dp
  import qpht_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ctrl_cmd_t           cmd,
  input  wire logic [SIZE_W-1:0]   table_size,
  input  wire logic [KEY_W-1:0]    in_key,
  input  wire logic [AGE_W-1:0]    in_age,
  input  wire logic                in_gender,
  output dp_stat_t                 stat,
  output logic [1:0]               out_status,
  output logic [SLOT_W-1:0]        out_slot,
  output logic [AGE_W-1:0]         out_found_age,
  output logic                     out_found_gender
);

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int NCAP = (TABLE_DEPTH < (2**SIZE_W) - 1) ? TABLE_DEPTH : (2**SIZE_W) - 1;

  function automatic logic [AW-1:0] to_addr(input logic [SIZE_W-1:0] v);
    logic [AW+SIZE_W-1:0] w;
    w = {{AW{1'b0}}, v};
    return w[AW-1:0];
  endfunction

  entry_t mem [TABLE_DEPTH];

  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [AGE_W-1:0]  age_r, age_nxt;
  logic              gen_r, gen_nxt;
  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic [SIZE_W-1:0] cnt_r, cnt_nxt;
  logic [SIZE_W-1:0] h_r, h_nxt;
  logic [SIZE_W-1:0] d_r, d_nxt;
  logic              qv_r, qv_nxt;
  logic [SIZE_W-1:0] qidx_r, qidx_nxt;
  entry_t            rdata_r;

  logic [1:0]        out_status_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [AGE_W-1:0]  out_age_r;
  logic              out_gen_r;

  logic [SIZE_W-1:0] live_n;
  logic [SIZE_W-1:0] raddr;
  logic              issue;
  logic [SIZE_W:0]   shifted;
  logic [SIZE_W:0]   hsum;
  logic [SIZE_W:0]   dsum;
  logic [SIZE_W:0]   n_ext;
  logic              we;
  logic [SIZE_W-1:0] waddr;
  entry_t            wdata;

  // Slots in use: zero acts as one, anything beyond the memory is clamped.
  always_comb begin
    if (table_size == '0) begin
      live_n = SIZE_W'(1);
    end else if (int'(table_size) > NCAP) begin
      live_n = SIZE_W'(NCAP);
    end else begin
      live_n = table_size;
    end
  end

  assign n_ext   = {1'b0, live_n};
  assign raddr   = cmd.probe ? h_r : cnt_r;
  assign issue   = cmd.run && (cnt_r < live_n);
  assign shifted = {rem_r, key_r[bit_r]};
  assign hsum    = {1'b0, h_r} + {1'b0, d_r};
  assign dsum    = {1'b0, d_r} + (SIZE_W+1)'(2);

  always_comb begin
    key_nxt  = key_r;
    age_nxt  = age_r;
    gen_nxt  = gen_r;
    rem_nxt  = rem_r;
    bit_nxt  = bit_r;
    cnt_nxt  = cnt_r;
    h_nxt    = h_r;
    d_nxt    = d_r;
    qv_nxt   = qv_r;
    qidx_nxt = qidx_r;

    if (cmd.load) begin
      key_nxt = in_key;
      age_nxt = in_age;
      gen_nxt = in_gender;
      rem_nxt = '0;
      bit_nxt = BIT_W'(KEY_W - 1);
    end

    // Restoring remainder, one key bit per cycle from the top.
    if (cmd.mod_en) begin
      rem_nxt = (shifted >= n_ext) ? SIZE_W'(shifted - n_ext) : shifted[SIZE_W-1:0];
      bit_nxt = bit_r - 1'b1;
    end

    if (cmd.scan_init) begin
      cnt_nxt = '0;
      qv_nxt  = 1'b0;
    end

    // Probe i sits at (key + i*i) mod n; the step to the next one is (2i + 1) mod n.
    if (cmd.probe_init) begin
      cnt_nxt = '0;
      qv_nxt  = 1'b0;
      h_nxt   = rem_r;
      d_nxt   = (live_n == SIZE_W'(1)) ? '0 : SIZE_W'(1);
    end

    if (cmd.run) begin
      if (issue) begin
        cnt_nxt  = cnt_r + 1'b1;
        qidx_nxt = raddr;
        qv_nxt   = 1'b1;
        if (cmd.probe) begin
          h_nxt = (hsum >= n_ext) ? SIZE_W'(hsum - n_ext) : hsum[SIZE_W-1:0];
          if (live_n == SIZE_W'(1)) begin
            d_nxt = '0;
          end else begin
            d_nxt = (dsum >= n_ext) ? SIZE_W'(dsum - n_ext) : dsum[SIZE_W-1:0];
          end
        end
      end else begin
        qv_nxt = 1'b0;
      end
    end

    if (cmd.clr_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_comb begin
    stat.mod_last = (bit_r == '0);
    stat.clr_last = (cnt_r == SIZE_W'(NCAP - 1));
    stat.miss     = !qv_r && (cnt_r >= live_n);
    if (cmd.probe) begin
      stat.hit = qv_r && (rdata_r.mark != MARK_USED);
    end else begin
      stat.hit = qv_r && (rdata_r.mark == MARK_USED) && (rdata_r.key == key_r);
    end
  end

  always_comb begin
    we    = cmd.clr_en || cmd.wr_del || cmd.wr_ins;
    waddr = cmd.clr_en ? cnt_r : qidx_r;
    wdata = rdata_r;
    if (cmd.clr_en) begin
      wdata = '{mark: MARK_EMPTY, gender: 1'b0, age: '0, key: '0};
    end else if (cmd.wr_ins) begin
      wdata = '{mark: MARK_USED, gender: gen_r, age: age_r, key: key_r};
    end else begin
      wdata.mark = MARK_DELETED;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[to_addr(waddr)] <= wdata;
    end
    rdata_r <= mem[to_addr(raddr)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      qv_r  <= 1'b0;
      bit_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      qv_r  <= qv_nxt;
      bit_r <= bit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    age_r  <= age_nxt;
    gen_r  <= gen_nxt;
    rem_r  <= rem_nxt;
    h_r    <= h_nxt;
    d_r    <= d_nxt;
    qidx_r <= qidx_nxt;
    if (cmd.res_load) begin
      out_status_r <= cmd.res_status;
      out_slot_r   <= cmd.res_slot ? qidx_r[SLOT_W-1:0] : '0;
      out_age_r    <= cmd.res_found ? rdata_r.age : '0;
      out_gen_r    <= cmd.res_found ? rdata_r.gender : 1'b0;
    end
  end

  assign out_status       = out_status_r;
  assign out_slot         = out_slot_r;
  assign out_found_age    = out_age_r;
  assign out_found_gender = out_gen_r;

endmodule

`default_nettype wire

// ===== hw/rtl/qpht_ctrl.sv =====
// Controller state machine of the quadratic probe hash table.
`default_nettype none

`include "quadratic_probe_hash_table_top_assert.svh"

module qpht_ctrl
  import qpht_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] in_command,
  input  wire dp_stat_t   stat,
  output logic            busy,
  output logic            out_valid,
  output ctrl_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_SCAN,
    S_PROBE
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] op_r, op_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    out_valid_nxt  = 1'b0;
    cmd            = '0;
    cmd.res_status = ST_NOTFOUND;

    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          op_nxt   = in_command;
          unique case (in_command) inside
            CMD_INSERT: begin
              state_nxt = S_MOD;
            end
            CMD_SEARCH, CMD_DELETE: begin
              cmd.scan_init = 1'b1;
              state_nxt     = S_SCAN;
            end
            default: begin
              cmd.res_load  = 1'b1;
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_MOD: begin
        cmd.mod_en = 1'b1;
        if (stat.mod_last) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end
      end

      S_SCAN: begin
        cmd.run = 1'b1;
        if (stat.hit) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          unique case (op_r) inside
            CMD_INSERT: begin
              cmd.res_status = ST_DUP;
            end
            CMD_SEARCH: begin
              cmd.res_status = ST_DONE;
              cmd.res_slot   = 1'b1;
              cmd.res_found  = 1'b1;
            end
            default: begin
              cmd.wr_del     = 1'b1;
              cmd.res_status = ST_DONE;
              cmd.res_slot   = 1'b1;
            end
          endcase
        end else if (stat.miss) begin
          if (op_r == CMD_INSERT) begin
            cmd.probe_init = 1'b1;
            state_nxt      = S_PROBE;
          end else begin
            cmd.res_load  = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end

      S_PROBE: begin
        cmd.run   = 1'b1;
        cmd.probe = 1'b1;
        if (stat.hit) begin
          cmd.wr_ins     = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_DONE;
          cmd.res_slot   = 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else if (stat.miss) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_FULL;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      op_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `QPHT_ASSERT_ALWAYS(a_hit_miss_excl, !(cmd.run && stat.hit && stat.miss), "hit and miss together")
  `QPHT_ASSERT_SAME(a_write_has_result, cmd.wr_del || cmd.wr_ins, cmd.res_load, "table write without result")
  `QPHT_ASSERT_NEXT(a_mod_holds, (state_r == S_MOD) && !stat.mod_last, state_r == S_MOD, "remainder cut short")
  `QPHT_ASSERT_NEXT(a_accept_busy, (state_r == S_IDLE) && start && (in_command == CMD_INSERT || in_command == CMD_SEARCH || in_command == CMD_DELETE), busy, "known command did not start work")

endmodule

`default_nettype wire

// ===== hw/rtl/quadratic_probe_hash_table_top.sv =====
// Top level of the quadratic probe hash table: configuration register and block wiring.
`default_nettype none

// Open-addressing record table with quadratic probing. A command word is taken
// when start is high while busy is low; exactly one result word follows on the
// out_ ports, marked by out_valid for a single cycle. The receiver cannot hold
// results off, so it must be ready to take every out_valid pulse. After reset the
// block runs a clearing pass over the min(TABLE_DEPTH, 127) reachable slots, one
// row per cycle, and stays busy until it ends. Work is done one word at a time
// through a single read port and a single write port of the slot memory. With n
// the live table size, a search or delete scans the slots in order from slot 0
// and answers at the first match, or after all n slots on a miss. An insert first
// reduces the key modulo n with a one-bit-per-cycle remainder unit, then scans
// the n slots for a duplicate, then probes (key + i*i) mod n for i counting up
// from 0, answering at the first free probe, or with full after n probes. An
// unknown command is answered in the cycle after acceptance and the block can
// take a new word in that same cycle. table_size may be written over the
// APB-style port only while the block is idle.

module quadratic_probe_hash_table_top
  import qpht_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  // Command channel.
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            in_command,
  input  wire logic [KEY_W-1:0]      in_key,
  input  wire logic [AGE_W-1:0]      in_age,
  input  wire logic                  in_gender,

  // Result channel.
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [SLOT_W-1:0]          out_slot,
  output logic [AGE_W-1:0]           out_found_age,
  output logic                       out_found_gender,

  // Configuration port.
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  logic [SIZE_W-1:0] table_size_r, table_size_nxt;
  logic              reg_sel;
  ctrl_cmd_t         cmd;
  dp_stat_t          stat;

  // The register index is the word address; the low byte-offset bits are ignored.
  assign reg_sel = (paddr[APB_ADDR_W-1] == REG_TABLE_SIZE);
  assign pready  = 1'b1;

  always_comb begin
    table_size_nxt = table_size_r;
    if (psel && penable && pwrite && pready && reg_sel) begin
      table_size_nxt = pwdata[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= TABLE_SIZE_RESET;
    end else begin
      table_size_r <= table_size_nxt;
    end
  end

  // Reads of any address outside the register list return zero.
  assign prdata = reg_sel ? {{(APB_DATA_W-SIZE_W){1'b0}}, table_size_r} : '0;

  // The controller sequences the remainder, scan and probe phases.
  qpht_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .stat       (stat),
    .busy       (busy),
    .out_valid  (out_valid),
    .cmd        (cmd)
  );

  // The datapath holds the slot memory and the result registers.
  qpht_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .table_size       (table_size_r),
    .in_key           (in_key),
    .in_age           (in_age),
    .in_gender        (in_gender),
    .stat             (stat),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_found_age    (out_found_age),
    .out_found_gender (out_found_gender)
  );

endmodule

`default_nettype wire

// ===== verif/quadratic_probe_hash_table_top_test.sv =====
// Self-checking testbench of the quadratic probe hash table: predicted replies per command word.
`timescale 1ns / 100ps

module quadratic_probe_hash_table_top_test;
  import qpht_pkg::*;

  localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
  // Command code 3 is not one of the package operations; the block must answer it as a miss.
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  // Address of table_size on the configuration port.
  localparam logic [APB_ADDR_W-1:0] ADDR_TABLE_SIZE = APB_ADDR_W'(4 * REG_TABLE_SIZE);
  // Cycles to let pass after the last reply: enough for the slowest insert (remainder unit,
  // duplicate scan and a probe pass over the whole table) plus some margin.
  localparam int TAIL_CYCLES = 2 * TABLE_DEPTH + 64;

  // One command word as it sits on the in_ ports.
  typedef struct packed {
    logic [1:0]       command;
    logic [KEY_W-1:0] key;
    logic [AGE_W-1:0] age;
    logic             gender;
  } table_cmd_t;

  // One reply word as it is expected on the out_ ports.
  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [AGE_W-1:0]  age;
    logic              gender;
  } table_reply_t;

  // Clock, reset and every block input start from a known value.
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic [1:0]            in_command = CMD_INSERT;
  logic [KEY_W-1:0]      in_key = '0;
  logic [AGE_W-1:0]      in_age = '0;
  logic                  in_gender = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;

  logic                  busy;
  logic                  out_valid;
  logic [1:0]            out_status;
  logic [SLOT_W-1:0]     out_slot;
  logic [AGE_W-1:0]      out_found_age;
  logic                  out_found_gender;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  quadratic_probe_hash_table_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_key           (in_key),
    .in_age           (in_age),
    .in_gender        (in_gender),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_found_age    (out_found_age),
    .out_found_gender (out_found_gender),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #1 clk = ~clk;

  // Our own copy of the table: slot marks, record fields and the size register.
  mark_t            slot_state [TABLE_DEPTH];
  logic [KEY_W-1:0] slot_key   [TABLE_DEPTH];
  logic [AGE_W-1:0] slot_age   [TABLE_DEPTH];
  logic             slot_gender[TABLE_DEPTH];
  logic [SIZE_W-1:0] table_size_reg = TABLE_SIZE_RESET;

  // Command words not yet offered, and replies still owed by the block, oldest first.
  table_cmd_t   commands_waiting[$];
  table_reply_t replies_due[$];
  table_cmd_t   word_on_ports;
  bit           word_up = 1'b0;

  int sender_idle_pct = 0;
  int errors = 0;
  int words_taken = 0;
  int replies_seen = 0;
  int sizes_run = 0;
  int status_count[4] = '{0, 0, 0, 0};
  logic [KEY_W-1:0] key_pool[$];

  initial begin
    for (int s = 0; s < TABLE_DEPTH; s++) begin
      slot_state[s] = MARK_EMPTY;
      slot_key[s] = '0;
      slot_age[s] = '0;
      slot_gender[s] = 1'b0;
    end
  end

  // Number of slots actually in play: a size of zero behaves as one slot, and anything
  // above the physical depth is clipped to the depth.
  function automatic int live_slots(logic [SIZE_W-1:0] size_val);
    int n;
    n = int'(size_val);
    if (n == 0) n = 1;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    return n;
  endfunction

  // Applies one command word to our table copy and returns the reply it must produce.
  // Search, delete and the duplicate check all look for the lowest occupied slot holding
  // the key; an insert then probes (key + i*i) mod n and takes the first slot that is
  // not occupied, so a deleted slot is reused.
  function automatic table_reply_t run_table_command(table_cmd_t w);
    table_reply_t     r;
    int               n;
    int               hit;
    int               s;
    bit               placed;
    longint unsigned  probe;
    r.status = ST_NOTFOUND;
    r.slot = '0;
    r.age = '0;
    r.gender = 1'b0;
    n = live_slots(table_size_reg);
    hit = n;
    for (int i = n - 1; i >= 0; i--) begin
      if (slot_state[i] == MARK_USED && slot_key[i] == w.key) hit = i;
    end
    case (w.command)
      CMD_INSERT: begin
        if (hit < n) begin
          r.status = ST_DUP;
        end else begin
          r.status = ST_FULL;
          placed = 1'b0;
          for (int i = 0; i < n; i++) begin
            probe = (longint'(w.key) + longint'(i) * longint'(i)) % longint'(n);
            s = int'(probe);
            if (!placed && slot_state[s] != MARK_USED) begin
              slot_state[s] = MARK_USED;
              slot_key[s] = w.key;
              slot_age[s] = w.age;
              slot_gender[s] = w.gender;
              r.status = ST_DONE;
              r.slot = s[SLOT_W-1:0];
              placed = 1'b1;
            end
          end
        end
      end
      CMD_SEARCH: begin
        if (hit < n) begin
          r.status = ST_DONE;
          r.slot = hit[SLOT_W-1:0];
          r.age = slot_age[hit];
          r.gender = slot_gender[hit];
        end
      end
      CMD_DELETE: begin
        if (hit < n) begin
          slot_state[hit] = MARK_DELETED;
          r.status = ST_DONE;
          r.slot = hit[SLOT_W-1:0];
        end
      end
      default: begin
        // An unknown command leaves the table alone and answers as a miss.
      end
    endcase
    return r;
  endfunction

  // Driver. A word is accepted at the edge where start is high and busy is low; it is
  // predicted at that moment, since the table copy must see commands in block order.
  // Once a word is raised it stays on the ports until taken. Between words the sender
  // idles at random according to the current phase.
  always @(posedge clk) begin
    table_cmd_t nxt;
    if (rst_n) begin
      if (start && !busy) begin
        replies_due.push_back(run_table_command(word_on_ports));
        words_taken++;
        word_up = 1'b0;
      end
      if (!word_up) begin
        if (commands_waiting.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = commands_waiting.pop_front();
          word_on_ports = nxt;
          in_command <= nxt.command;
          in_key <= nxt.key;
          in_age <= nxt.age;
          in_gender <= nxt.gender;
          start <= 1'b1;
          word_up = 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor. The receiver cannot hold results off, so every out_valid strobe is a reply
  // word and is checked against the oldest reply still due.
  always @(posedge clk) begin
    table_reply_t want;
    if (rst_n && out_valid) begin
      if (replies_due.size() == 0) begin
        $error("reply word with none due: status %0d slot %0d", out_status, out_slot);
        errors++;
      end else begin
        want = replies_due.pop_front();
        replies_seen++;
        status_count[want.status]++;
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          errors++;
        end
        if (out_slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, out_slot);
          errors++;
        end
        if (out_found_age !== want.age) begin
          $error("found_age: expected %0d, got %0d", want.age, out_found_age);
          errors++;
        end
        if (out_found_gender !== want.gender) begin
          $error("found_gender: expected %0d, got %0d", want.gender, out_found_gender);
          errors++;
        end
      end
    end
  end

  task automatic queue_word(logic [1:0] cmd, logic [KEY_W-1:0] key, logic [AGE_W-1:0] age,
                            logic gender);
    table_cmd_t w;
    w.command = cmd;
    w.key = key;
    w.age = age;
    w.gender = gender;
    commands_waiting.push_back(w);
  endtask

  // Returns once every queued word has been taken and every reply has arrived.
  task automatic wait_for_replies();
    do @(posedge clk);
    while (commands_waiting.size() != 0 || word_up || replies_due.size() != 0);
  endtask

  // Writes table_size over the configuration port while the block is idle, then reads
  // it back. The write lands at the access edge, so our copy changes there too.
  task automatic write_table_size(logic [SIZE_W-1:0] size_val);
    wait_for_replies();
    while (busy) @(posedge clk);
    repeat (4) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_TABLE_SIZE;
    pwdata <= APB_DATA_W'(size_val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    table_size_reg = size_val;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== APB_DATA_W'(size_val)) begin
      $error("table_size readback: expected %0d, got %0d", size_val, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Keys come in several flavors: the two extremes, small values of at most three
  // times the table size, families that all land on the same home slot, and full-width
  // random keys that toggle every bit.
  function automatic logic [KEY_W-1:0] pick_key(int n);
    int kind;
    kind = $urandom_range(9);
    if (kind == 0) return '0;
    if (kind == 1) return '1;
    if (kind <= 4) return KEY_W'($urandom_range(3 * n));
    if (kind <= 7) return KEY_W'(($urandom() >> 2) / n * n + n * $urandom_range(7));
    return KEY_W'($urandom());
  endfunction

  // One phase of random traffic at one table size. Most words use a small pool of keys
  // so that inserts, searches and deletes keep meeting each other; the rest use fresh
  // keys. Optionally the sender stops halfway until the block has answered everything.
  task automatic run_phase(logic [SIZE_W-1:0] size_val, int count, int idle_pct,
                           bit drain_midway);
    int n;
    int pool_len;
    int pick;
    logic [1:0] cmd;
    logic [KEY_W-1:0] key;
    write_table_size(size_val);
    sender_idle_pct = idle_pct;
    sizes_run++;
    n = live_slots(size_val);
    pool_len = n + n / 2;
    if (pool_len < 4) pool_len = 4;
    if (pool_len > 48) pool_len = 48;
    key_pool.delete();
    for (int i = 0; i < pool_len; i++) key_pool.push_back(pick_key(n));
    for (int i = 0; i < count; i++) begin
      if (drain_midway && i == count / 2) wait_for_replies();
      pick = $urandom_range(99);
      if (pick < 42) cmd = CMD_INSERT;
      else if (pick < 72) cmd = CMD_SEARCH;
      else if (pick < 95) cmd = CMD_DELETE;
      else cmd = CMD_UNKNOWN;
      if ($urandom_range(9) != 0) key = key_pool[$urandom_range(pool_len - 1)];
      else key = pick_key(n);
      queue_word(cmd, key, AGE_W'($urandom_range(127)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset size of 53 slots: extreme keys and fields, duplicate
    // insert, misses, delete then miss, reuse of a deleted slot, probe collisions that
    // step to the i = 1 and i = 2 probes, and the unknown command.
    sender_idle_pct = 0;
    sizes_run++;
    queue_word(CMD_INSERT, '0, '0, 1'b0);
    queue_word(CMD_INSERT, '1, '1, 1'b1);
    queue_word(CMD_INSERT, '0, 7'd9, 1'b1);
    queue_word(CMD_SEARCH, '0, '1, 1'b1);
    queue_word(CMD_SEARCH, '1, '0, 1'b0);
    queue_word(CMD_SEARCH, 31'd12345, '0, 1'b0);
    queue_word(CMD_DELETE, '0, '0, 1'b0);
    queue_word(CMD_DELETE, '0, '0, 1'b0);
    queue_word(CMD_SEARCH, '0, '0, 1'b0);
    queue_word(CMD_INSERT, 31'd53, 7'd5, 1'b1);
    queue_word(CMD_INSERT, 31'd106, 7'd6, 1'b0);
    queue_word(CMD_INSERT, '0, 7'd7, 1'b1);
    queue_word(CMD_SEARCH, '0, '0, 1'b0);
    queue_word(CMD_UNKNOWN, '1, '1, 1'b1);
    queue_word(CMD_UNKNOWN, '0, '0, 1'b0);
    queue_word(CMD_DELETE, '1, '1, 1'b1);
    queue_word(CMD_INSERT, 31'h2AAAAAAA, 7'h55, 1'b0);
    queue_word(CMD_INSERT, 31'h55555555, 7'h2A, 1'b1);
    queue_word(CMD_SEARCH, 31'h2AAAAAAA, '0, 1'b0);
    queue_word(CMD_SEARCH, 31'h55555555, '0, 1'b0);
    queue_word(CMD_DELETE, 31'd53, '0, 1'b0);
    queue_word(CMD_DELETE, 31'd106, '0, 1'b0);
    queue_word(CMD_SEARCH, 31'd106, '0, 1'b0);

    // Random phases. The table is never cleared between them, so shrinking and growing
    // the size hides and then exposes records above the live range. The size sequence
    // covers zero, one, two, the full depth, an oversized value and several primes.
    run_phase(7'd53, 200, 48, 1'b0);
    run_phase(7'd1, 60, 25, 1'b0);
    run_phase(7'd0, 40, 0, 1'b0);
    run_phase(7'd2, 60, 48, 1'b0);
    run_phase(7'd127, 200, 0, 1'b1);
    run_phase(7'd64, 200, 25, 1'b0);
    run_phase(7'd7, 120, 48, 1'b0);
    run_phase(7'd13, 140, 0, 1'b0);
    run_phase(7'd31, 150, 25, 1'b0);
    run_phase(TABLE_SIZE_RESET, 130, 48, 1'b0);

    wait_for_replies();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d command words over %0d table sizes with %0d replies checked.",
             words_taken, sizes_run, replies_seen);
    $display("Replies: %0d done, %0d duplicate, %0d full, %0d not found.",
             status_count[ST_DONE], status_count[ST_DUP], status_count[ST_FULL],
             status_count[ST_NOTFOUND]);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, including the clearing pass after reset.
  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
